@@ hw/rtl/dps_pkg.sv @@
// Shared types and constants for the dual pedal sensor plausibility unit.
package dps_pkg;

  localparam int SAMPLE_W = 12;
  localparam int AVG_LEN  = 10;
  localparam int POS_W    = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;
  localparam int SUM_W    = SAMPLE_W + POS_W;

  // Divide by AVG_LEN as multiply by a rounded-up reciprocal and shift.
  localparam int RECIP_SHIFT = SUM_W + 3;
  localparam int RECIP_W     = RECIP_SHIFT - POS_W + 1;
  localparam int MUL_W       = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((1 << RECIP_SHIFT) + AVG_LEN - 1) / AVG_LEN);

  // Throttle scaling: mean * 100 / 4095, with 4095 = 2**12 - 1.
  localparam int FS_SHIFT = 12;
  localparam int PCT_W    = 7;
  localparam int SCALED_W = SAMPLE_W + PCT_W;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = SAMPLE_W'((1 << FS_SHIFT) - 1);
  localparam logic [PCT_W-1:0]    PCT_MAX    = PCT_W'(100);

  localparam int CFG_IDX_W = 4;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_POT1_OPEN   = 3'd1,
    ST_POT2_OPEN   = 3'd2,
    ST_POT1_SHORT  = 3'd3,
    ST_IMPLAUSIBLE = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_VALID     = 4'd0,
    REG_MAX_VALID     = 4'd1,
    REG_DEV_LIMIT     = 4'd2,
    REG_RELEASE_LEVEL = 4'd3
  } cfg_reg_t;

  localparam logic [SAMPLE_W-1:0] MIN_VALID_RST     = SAMPLE_W'(100);
  localparam logic [SAMPLE_W-1:0] MAX_VALID_RST     = SAMPLE_W'(4000);
  localparam logic [SAMPLE_W-1:0] DEV_LIMIT_RST     = SAMPLE_W'(400);
  localparam logic [SAMPLE_W-1:0] RELEASE_LEVEL_RST = SAMPLE_W'(300);

endpackage

@@ hw/rtl/dps_in_if.sv @@
// Input channel: one pair of raw potentiometer samples per transfer.
interface dps_in_if;
  import dps_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] pot1_sample;
  logic [SAMPLE_W-1:0] pot2_sample;
  modport source (output valid, output pot1_sample, output pot2_sample, input ready);
  modport sink   (input valid, input pot1_sample, input pot2_sample, output ready);
endinterface

@@ hw/rtl/dps_out_if.sv @@
// Result channel: throttle demand, status and filtered levels per transfer.
interface dps_out_if;
  import dps_pkg::*;
  logic                valid;
  logic                ready;
  logic [PCT_W-1:0]    throttle_demand;
  status_t             pedal_status;
  logic                safe_locked;
  logic [SAMPLE_W-1:0] pot1_filtered;
  logic [SAMPLE_W-1:0] pot2_filtered;
  modport source (output valid, output throttle_demand, output pedal_status,
                  output safe_locked, output pot1_filtered, output pot2_filtered,
                  input ready);
  modport sink   (input valid, input throttle_demand, input pedal_status,
                  input safe_locked, input pot1_filtered, input pot2_filtered,
                  output ready);
endinterface

@@ hw/rtl/dps_cfg_if.sv @@
// Configuration write channel: register index and write data per transfer.
interface dps_cfg_if;
  import dps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SAMPLE_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/dps_ring.sv @@
// Moving-average ring for one channel with a running sum register.
module dps_ring (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [dps_pkg::SAMPLE_W-1:0]   sample,
  input  logic [dps_pkg::POS_W-1:0]      pos,
  output logic [dps_pkg::SUM_W-1:0]      sum
);
  import dps_pkg::*;

  logic [SAMPLE_W-1:0] entries [AVG_LEN];
  logic [SUM_W-1:0]    sum_next;

  // Drop the oldest sample, add the new one; the sum never goes negative.
  assign sum_next = sum - SUM_W'(entries[pos]) + SUM_W'(sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < AVG_LEN; k++) begin
        entries[k] <= '0;
      end
      sum <= '0;
    end else if (push) begin
      entries[pos] <= sample;
      sum          <= sum_next;
    end
  end

endmodule

@@ hw/rtl/dual_pedal_sensor_plausibility_unit.sv @@
// Dual pedal sensor plausibility unit: averages, fault checks and safe-state latch.
//
// Each input transfer carries one sample pair from the two redundant pedal
// potentiometers. Each sample enters a ten-entry moving-average ring kept
// with a running sum, so each filtered level is the ring sum divided by ten
// (truncated). The filtered levels are checked in priority order: pot1 below
// min_valid, pot2 below min_valid, pot1 above max_valid, then a difference
// above dev_limit. Any fault latches the safe state with zero throttle;
// the latch releases on a fault-free item whose mean level is below
// release_level, and that item still reports zero throttle. Otherwise the
// throttle is mean * 100 / 4095. Rate: one item per clock while the result
// side is not stalled. Each item passes four register stages (ring sum,
// reciprocal divide, fault check and latch, percent scaling into the output
// register) before its result is valid. Stages advance independently, so
// bubbles fill while a result waits at the output register.
// Configuration registers are written through the cfg channel, which is
// always ready; writes to an index outside the register list are dropped.
// Write configuration only while no item is in flight.
module dual_pedal_sensor_plausibility_unit (
  input logic       clk,
  input logic       rst,
  dps_in_if.sink    pedal,
  dps_out_if.source report,
  dps_cfg_if.sink   cfg
);
  import dps_pkg::*;

  // Configuration registers
  logic [SAMPLE_W-1:0] min_valid;
  logic [SAMPLE_W-1:0] max_valid;
  logic [SAMPLE_W-1:0] dev_limit;
  logic [SAMPLE_W-1:0] release_level;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_valid     <= MIN_VALID_RST;
      max_valid     <= MAX_VALID_RST;
      dev_limit     <= DEV_LIMIT_RST;
      release_level <= RELEASE_LEVEL_RST;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_MIN_VALID:     min_valid     <= cfg.data;
        REG_MAX_VALID:     max_valid     <= cfg.data;
        REG_DEV_LIMIT:     dev_limit     <= cfg.data;
        REG_RELEASE_LEVEL: release_level <= cfg.data;
        default: ; // drop writes outside the register list
      endcase
    end
  end

  // Stage flow control: a stage moves on when the stage after it is empty
  // or moving on itself.
  logic v1, v2, v3;
  logic out_free, free3, free2, free1;
  logic accept, adv2;

  assign out_free    = !report.valid || report.ready;
  assign free3       = !v3 || out_free;
  assign free2       = !v2 || free3;
  assign free1       = !v1 || free2;
  assign pedal.ready = free1;
  assign accept      = pedal.valid && free1;
  assign adv2        = v2 && free3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      report.valid <= 1'b0;
    end else begin
      if (free1)    v1           <= accept;
      if (free2)    v2           <= v1;
      if (free3)    v3           <= v2;
      if (out_free) report.valid <= v3;
    end
  end

  // Stage 1: rings and running sums, shared write position.
  logic [POS_W-1:0] ring_pos;
  logic [SUM_W-1:0] sum1, sum2;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pos <= '0;
    end else if (accept) begin
      ring_pos <= (ring_pos == POS_W'(AVG_LEN - 1)) ? '0 : ring_pos + 1'b1;
    end
  end

  dps_ring u_ring_one (
    .clk    (clk),
    .rst    (rst),
    .push   (accept),
    .sample (pedal.pot1_sample),
    .pos    (ring_pos),
    .sum    (sum1)
  );

  dps_ring u_ring_two (
    .clk    (clk),
    .rst    (rst),
    .push   (accept),
    .sample (pedal.pot2_sample),
    .pos    (ring_pos),
    .sum    (sum2)
  );

  // Stage 2: divide each sum by the ring length through the reciprocal.
  logic [MUL_W-1:0]    prod1, prod2;
  logic [SAMPLE_W-1:0] f1, f2;

  assign prod1 = MUL_W'(sum1) * MUL_W'(AVG_RECIP);
  assign prod2 = MUL_W'(sum2) * MUL_W'(AVG_RECIP);

  always_ff @(posedge clk) begin
    if (v1 && free2) begin
      f1 <= prod1[RECIP_SHIFT +: SAMPLE_W];
      f2 <= prod2[RECIP_SHIFT +: SAMPLE_W];
    end
  end

  // Stage 3: fault check, safe-state latch, mean and percent product.
  logic                latch;
  status_t             held;
  logic [SAMPLE_W-1:0] diff;
  logic [SAMPLE_W-1:0] mean;
  status_t             fault;
  logic                latch_next;
  status_t             held_next;
  logic                thr_en;

  assign diff = (f1 > f2) ? (f1 - f2) : (f2 - f1);
  assign mean = SAMPLE_W'(({1'b0, f1} + {1'b0, f2}) >> 1);

  always_comb begin
    if (f1 < min_valid) begin
      fault = ST_POT1_OPEN;
    end else if (f2 < min_valid) begin
      fault = ST_POT2_OPEN;
    end else if (f1 > max_valid) begin
      fault = ST_POT1_SHORT;
    end else if (diff > dev_limit) begin
      fault = ST_IMPLAUSIBLE;
    end else begin
      fault = ST_OK;
    end

    latch_next = latch;
    held_next  = held;
    thr_en     = 1'b0;
    if (fault != ST_OK) begin
      // Set or hold the safe state with the newest fault code.
      latch_next = 1'b1;
      held_next  = fault;
    end else if (latch) begin
      // Release only on a clean item with the pedal near rest.
      if (mean < release_level) begin
        latch_next = 1'b0;
        held_next  = ST_OK;
      end
    end else begin
      thr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch <= 1'b0;
      held  <= ST_OK;
    end else if (adv2) begin
      latch <= latch_next;
      held  <= held_next;
    end
  end

  logic [SAMPLE_W-1:0] f1_r3, f2_r3;
  logic [SCALED_W-1:0] scaled_r3;
  status_t             status_r3;
  logic                lock_r3;
  logic                thr_en_r3;

  always_ff @(posedge clk) begin
    if (adv2) begin
      f1_r3     <= f1;
      f2_r3     <= f2;
      scaled_r3 <= SCALED_W'(mean) * SCALED_W'(PCT_MAX);
      status_r3 <= held_next;
      lock_r3   <= latch_next;
      thr_en_r3 <= thr_en;
    end
  end

  // Stage 4: divide by 4095. Take the quotient by 4096, then correct once:
  // the remainder against 4095 is the low bits plus that quotient.
  logic [PCT_W-1:0]    q0;
  logic [FS_SHIFT:0]   rem;
  logic [PCT_W-1:0]    pct;

  assign q0  = PCT_W'(scaled_r3 >> FS_SHIFT);
  assign rem = (FS_SHIFT + 1)'(scaled_r3[FS_SHIFT-1:0]) + (FS_SHIFT + 1)'(q0);
  assign pct = (rem >= (FS_SHIFT + 1)'(FULL_SCALE)) ? q0 + 1'b1 : q0;

  always_ff @(posedge clk) begin
    if (v3 && out_free) begin
      report.throttle_demand <= thr_en_r3 ? pct : '0;
      report.pedal_status    <= status_r3;
      report.safe_locked     <= lock_r3;
      report.pot1_filtered   <= f1_r3;
      report.pot2_filtered   <= f2_r3;
    end
  end

  // Checks
  a_locked_zero_throttle: assert property (@(posedge clk) disable iff (rst)
    report.valid && report.safe_locked |-> report.throttle_demand == '0)
    else $error("throttle demand while safe state is latched");

  a_fault_implies_lock: assert property (@(posedge clk) disable iff (rst)
    report.valid && report.pedal_status != ST_OK |-> report.safe_locked)
    else $error("fault status reported without safe state");

  a_latch_status_agree: assert property (@(posedge clk) disable iff (rst)
    (latch == 1'b0) == (held == ST_OK))
    else $error("latch and held status disagree");

  a_throttle_range: assert property (@(posedge clk) disable iff (rst)
    report.valid |-> report.throttle_demand <= PCT_MAX)
    else $error("throttle demand above full scale");

endmodule
